[src/adre_pkg.sv]
// Shared widths, register map and reset values of the adaptive decay rate estimator.
`default_nettype none
package adre_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int RATE_BITS_DEF  = 32;
	localparam int SUM_W_DEF      = 38;

	localparam int SAMPLE_W   = 32;
	localparam int HEADROOM_W = 18;
	localparam int DCFG_W     = 17;
	localparam int WIN_W      = 7;
	localparam int RATIO_W    = 18;
	localparam int DECAY_W    = 20;
	localparam int DACC_W     = 38;
	localparam int LIMB_W     = 16;
	localparam int FRAC_W     = 16;

	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_HEADROOM  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_MIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DECAY_MAX = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd3;

	localparam logic [HEADROOM_W-1:0] HEADROOM_RST  = 18'd65536;
	localparam logic [DCFG_W-1:0]     DECAY_MIN_RST = 17'd62259;
	localparam logic [DCFG_W-1:0]     DECAY_MAX_RST = 17'd65536;
	localparam logic [WIN_W-1:0]      WINDOW_RST    = 7'd8;

endpackage
`default_nettype wire

[src/adaptive_decay_rate_estimator.sv]
// Top level of the adaptive decay rate estimator: config port, sequencer and envelope.
// Steps per item: history update, divide, decay multiply and add, envelope (multiply when it decays).
// The input stalls until an item is through, so one item is in flight; the 18-step divider is the longest part.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset clears sums, fill count, pointer, envelope, pending estimate and seed flag; rings stay.
`default_nettype none
module adaptive_decay_rate_estimator #(
	parameter int MAX_WINDOW = adre_pkg::MAX_WINDOW_DEF,
	parameter int RATE_BITS  = adre_pkg::RATE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adre_pkg::ADDR_W-1:0]   paddr,
	input  logic [adre_pkg::DATA_W-1:0]   pwdata,
	output logic [adre_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [adre_pkg::SAMPLE_W-1:0] rate_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [adre_pkg::SAMPLE_W-1:0] next_estimate
);

	localparam int W_W    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = RATE_BITS + $clog2(MAX_WINDOW);
	localparam int CMP_W  = (W_W > adre_pkg::WIN_W) ? W_W : adre_pkg::WIN_W;
	localparam int EXT_W  = (RATE_BITS > adre_pkg::SAMPLE_W) ? RATE_BITS : adre_pkg::SAMPLE_W;
	localparam int DCFG_W = adre_pkg::DCFG_W;
	localparam int RW     = adre_pkg::RATIO_W;
	localparam int DEC_W  = adre_pkg::DECAY_W;
	localparam int DACC_W = adre_pkg::DACC_W;
	localparam int FRAC_W = adre_pkg::FRAC_W;
	localparam int PROD_W = DCFG_W + RW + 2;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HIST = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DMUL = 3'd3;
	localparam logic [2:0] S_DACC = 3'd4;
	localparam logic [2:0] S_ENV  = 3'd5;
	localparam logic [2:0] S_EMUL = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	// configuration registers
	logic [adre_pkg::HEADROOM_W-1:0] hg_q;
	logic [DCFG_W-1:0]               dmin_q;
	logic [DCFG_W-1:0]               dmax_q;
	logic [adre_pkg::WIN_W-1:0]      win_q;
	logic                            wr_en;
	logic                            win_wr;
	logic [adre_pkg::REG_IDX_W-1:0]  reg_idx;

	// sequencer and envelope state
	logic [2:0]            state_q;
	logic                  seeded_q;
	logic [RATE_BITS-1:0]  pend_q;
	logic [RATE_BITS-1:0]  env_q;
	logic                  out_valid_q;
	logic [adre_pkg::SAMPLE_W-1:0] out_data_q;
	logic                  scaled_ok_q;
	logic [RATE_BITS-1:0]  scaled_q;
	logic [RW-1:0]         ratio_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [DEC_W-1:0]      decay_q;

	// datapath nets
	logic                  accept;
	logic                  load_out;
	logic [CMP_W-1:0]      win_ext;
	logic [W_W-1:0]        eff_win;
	logic [EXT_W-1:0]      samp_ext;
	logic [RATE_BITS-1:0]  s_sat;
	logic [RATE_BITS-1:0]  hist_est;
	logic                  hist_done;
	logic [SUM_W-1:0]      ssum;
	logic [SUM_W-1:0]      esum;
	logic                  div_start;
	logic                  div_done;
	logic [RW-1:0]         div_ratio;
	logic                  mul_start;
	logic [RATE_BITS-1:0]  mul_a;
	logic [DEC_W-1:0]      mul_b;
	logic                  mul_done;
	logic [RATE_BITS-1:0]  mul_res;
	logic                  scaled_gt;
	logic signed [DCFG_W:0]   ddiff;
	logic signed [DACC_W-1:0] dacc;
	logic [DEC_W-1:0]      decay_nxt;
	logic [EXT_W-1:0]      env_ext;

	// ---------------------------------------------------------------------
	// Configuration port: writes land in the access phase, reads are muxed.
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[adre_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign win_wr  = wr_en && (reg_idx == adre_pkg::REG_WINDOW);

	always_comb begin
		case (reg_idx)
			adre_pkg::REG_HEADROOM:  prdata = adre_pkg::DATA_W'(hg_q);
			adre_pkg::REG_DECAY_MIN: prdata = adre_pkg::DATA_W'(dmin_q);
			adre_pkg::REG_DECAY_MAX: prdata = adre_pkg::DATA_W'(dmax_q);
			adre_pkg::REG_WINDOW:    prdata = adre_pkg::DATA_W'(win_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hg_q   <= adre_pkg::HEADROOM_RST;
			dmin_q <= adre_pkg::DECAY_MIN_RST;
			dmax_q <= adre_pkg::DECAY_MAX_RST;
			win_q  <= adre_pkg::WINDOW_RST;
		end else if (wr_en) begin
			case (reg_idx)
				adre_pkg::REG_HEADROOM:  hg_q   <= pwdata[adre_pkg::HEADROOM_W-1:0];
				adre_pkg::REG_DECAY_MIN: dmin_q <= pwdata[DCFG_W-1:0];
				adre_pkg::REG_DECAY_MAX: dmax_q <= pwdata[DCFG_W-1:0];
				adre_pkg::REG_WINDOW:    win_q  <= pwdata[adre_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective window: zero acts as one, anything past the ring depth is clamped.
	assign win_ext = CMP_W'(win_q);
	always_comb begin
		if (win_ext == '0) begin
			eff_win = W_W'(1);
		end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
			eff_win = W_W'(MAX_WINDOW);
		end else begin
			eff_win = win_ext[W_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Input side: one item at a time; saturate the sample to the rate width.
	// ---------------------------------------------------------------------
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign samp_ext = EXT_W'(rate_sample);
	assign s_sat    = (samp_ext > EXT_W'({RATE_BITS{1'b1}})) ? {RATE_BITS{1'b1}}
	                                                         : samp_ext[RATE_BITS-1:0];
	// the very first pair uses the sample itself as its estimate
	assign hist_est = seeded_q ? pend_q : s_sat;

	adre_hist #(
		.MAX_WINDOW (MAX_WINDOW),
		.RATE_BITS  (RATE_BITS)
	) u_hist (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (win_wr),
		.start        (accept),
		.win          (eff_win),
		.samp         (s_sat),
		.est          (hist_est),
		.done         (hist_done),
		.sample_sum   (ssum),
		.estimate_sum (esum)
	);

	assign div_start = (state_q == S_HIST) && hist_done;

	adre_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ssum),
		.den    (esum),
		.done   (div_done),
		.ratio  (div_ratio)
	);

	// Shared multiplier: sample * headroom at accept (overlaps the history update and divide),
	// then envelope * decay when the envelope does not jump up.
	assign scaled_gt = (scaled_q > env_q);
	assign mul_start = accept || ((state_q == S_ENV) && scaled_ok_q && !scaled_gt);
	assign mul_a     = (state_q == S_IDLE) ? s_sat : env_q;
	assign mul_b     = (state_q == S_IDLE) ? DEC_W'(hg_q) : decay_q;

	adre_mul #(
		.A_W (RATE_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	// decay = decay_min + (decay_max - decay_min) * ratio, clamped at zero
	assign ddiff     = $signed({1'b0, dmax_q}) - $signed({1'b0, dmin_q});
	assign dacc      = $signed({{(DACC_W-DCFG_W-FRAC_W){1'b0}}, dmin_q, {FRAC_W{1'b0}}})
	                 + DACC_W'(prod_s1);
	assign decay_nxt = dacc[DACC_W-1] ? '0 : dacc[FRAC_W+DEC_W-1:FRAC_W];

	// ---------------------------------------------------------------------
	// Output side: the result register holds until the consumer takes it.
	// ---------------------------------------------------------------------
	assign load_out      = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign env_ext       = EXT_W'(env_q);
	assign out_valid     = out_valid_q;
	assign next_estimate = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			pend_q      <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
			scaled_ok_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				scaled_ok_q <= 1'b0;
			end else if (mul_done && (state_q != S_EMUL)) begin
				scaled_ok_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HIST;
						if (!seeded_q) begin
							seeded_q <= 1'b1;
							pend_q   <= s_sat;
						end
					end
				end
				S_HIST: begin
					if (hist_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					state_q <= S_DACC;
				end
				S_DACC: begin
					state_q <= S_ENV;
				end
				S_ENV: begin
					// jump up to the scaled sample, or decay toward it
					if (scaled_ok_q) begin
						if (scaled_gt) begin
							env_q   <= scaled_q;
							state_q <= S_OUT;
						end else begin
							state_q <= S_EMUL;
						end
					end
				end
				S_EMUL: begin
					if (mul_done) begin
						env_q   <= (mul_res < scaled_q) ? scaled_q : mul_res;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						pend_q  <= env_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_done && (state_q != S_EMUL)) begin
			scaled_q <= mul_res;
		end
		if (div_done) begin
			ratio_q <= div_ratio;
		end
		if (state_q == S_DMUL) begin
			prod_s1 <= ddiff * $signed({1'b0, ratio_q});
		end
		if (state_q == S_DACC) begin
			decay_q <= decay_nxt;
		end
		if (load_out) begin
			out_data_q <= env_ext[adre_pkg::SAMPLE_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_hist_done_in_hist: assert property (@(posedge clk) disable iff (!arst_n)
		hist_done |-> (state_q == S_HIST))
		else $error("history update finished outside the history step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	a_scaled_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DACC) |-> scaled_ok_q)
		else $error("scaled sample not ready before the envelope step");

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		win_wr |=> ((ssum == '0) && (esum == '0)))
		else $error("window write did not clear the history sums");
`endif

endmodule
`default_nettype wire

[src/adre_mul.sv]
// Limb-serial Q16 multiplier: floor(a * b / 2^16), saturated to the width of a.
`default_nettype none
module adre_mul #(
	parameter int A_W = adre_pkg::RATE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [A_W-1:0]              a,
	input  logic [adre_pkg::DECAY_W-1:0] b,
	output logic                        done,
	output logic [A_W-1:0]              res
);

	localparam int LW    = adre_pkg::LIMB_W;
	localparam int B_W   = adre_pkg::DECAY_W;
	localparam int LIMBS = (A_W + LW - 1) / LW;
	localparam int AP_W  = LIMBS * LW;
	localparam int ACC_W = AP_W + B_W;
	localparam int HI_W  = ACC_W - adre_pkg::FRAC_W;
	localparam int CNT_W = $clog2(LIMBS + 1);

	logic [AP_W-1:0]    a_q;
	logic [B_W-1:0]     b_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [LW+B_W-1:0]  part;
	logic [ACC_W-1:0]   acc_nxt;
	logic [HI_W-1:0]    hi;

	// most significant limb first: shift the accumulator one limb per step
	assign part    = (LW+B_W)'(a_q[AP_W-1 -: LW]) * (LW+B_W)'(b_q);
	assign acc_nxt = (acc_q << LW) + ACC_W'(part);
	assign hi      = acc_q[ACC_W-1:adre_pkg::FRAC_W];
	assign res     = (|hi[HI_W-1:A_W]) ? {A_W{1'b1}} : hi[A_W-1:0];
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LIMBS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= AP_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << LW;
			acc_q <= acc_nxt;
		end
	end

endmodule
`default_nettype wire

[src/adre_div.sv]
// Restoring divider for the Q2.16 ratio of the history sums, saturating.
`default_nettype none
module adre_div #(
	parameter int SUM_W = adre_pkg::SUM_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SUM_W-1:0]             num,
	input  logic [SUM_W-1:0]             den,
	output logic                         done,
	output logic [adre_pkg::RATIO_W-1:0] ratio
);

	localparam int RW    = adre_pkg::RATIO_W;
	localparam int CNT_W = $clog2(RW + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   rem_q;
	logic [RW-1:0]      dvd_q;
	logic [SUM_W-1:0]   den_q;
	logic [RW-1:0]      quo_q;
	logic [SUM_W:0]     trial;
	logic [SUM_W:0]     trial_sub;
	logic               ge;
	logic               den_zero;
	logic               sat;

	assign den_zero  = (den == '0);
	// quotient of four or more saturates the ratio
	assign sat       = ({2'b00, num} >= {den, 2'b00});
	assign trial     = {rem_q, dvd_q[RW-1]};
	assign ge        = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign done      = done_q;
	assign ratio     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den_zero || sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(RW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend is num * 2^16; its top part starts below den since num < 4 * den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num >> 2;
			dvd_q <= {num[1:0], {(RW-2){1'b0}}};
			den_q <= den;
			quo_q <= (sat && !den_zero) ? {RW{1'b1}} : '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[RW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

[src/adre_hist.sv]
// Sample and estimate history rings with running window sums.
`default_nettype none
module adre_hist #(
	parameter int MAX_WINDOW = adre_pkg::MAX_WINDOW_DEF,
	parameter int RATE_BITS  = adre_pkg::RATE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      clear,
	input  logic                                      start,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]           win,
	input  logic [RATE_BITS-1:0]                      samp,
	input  logic [RATE_BITS-1:0]                      est,
	output logic                                      done,
	output logic [RATE_BITS+$clog2(MAX_WINDOW)-1:0]   sample_sum,
	output logic [RATE_BITS+$clog2(MAX_WINDOW)-1:0]   estimate_sum
);

	localparam int W_W   = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W = RATE_BITS + $clog2(MAX_WINDOW);

	logic [RATE_BITS-1:0] samp_mem [MAX_WINDOW];
	logic [RATE_BITS-1:0] est_mem  [MAX_WINDOW];

	logic [W_W-1:0]       fill_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [SUM_W-1:0]     ssum_q;
	logic [SUM_W-1:0]     esum_q;
	logic                 done_q;
	logic                 valid_s1;
	logic [PTR_W-1:0]     p_s1;
	logic [RATE_BITS-1:0] samp_s1;
	logic [RATE_BITS-1:0] est_s1;
	logic [RATE_BITS-1:0] rd_samp_s1;
	logic [RATE_BITS-1:0] rd_est_s1;

	logic [PTR_W-1:0]     p;
	logic                 full;
	logic [W_W-1:0]       p_inc;
	logic [PTR_W-1:0]     ptr_nxt;
	logic [SUM_W-1:0]     old_s;
	logic [SUM_W-1:0]     old_e;

	assign p       = (W_W'(ptr_q) >= win) ? '0 : ptr_q;
	assign full    = (fill_q >= win);
	assign p_inc   = W_W'(p_s1) + W_W'(1);
	assign ptr_nxt = (p_inc >= win) ? '0 : p_inc[PTR_W-1:0];
	// a full window drops the oldest pair as the new one goes in
	assign old_s   = full ? SUM_W'(rd_samp_s1) : '0;
	assign old_e   = full ? SUM_W'(rd_est_s1) : '0;

	assign done         = done_q;
	assign sample_sum   = ssum_q;
	assign estimate_sum = esum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			fill_q   <= '0;
			ptr_q    <= '0;
			ssum_q   <= '0;
			esum_q   <= '0;
		end else begin
			valid_s1 <= start;
			done_q   <= valid_s1;
			if (clear) begin
				fill_q <= '0;
				ptr_q  <= '0;
				ssum_q <= '0;
				esum_q <= '0;
			end else if (valid_s1) begin
				ssum_q <= ssum_q - old_s + SUM_W'(samp_s1);
				esum_q <= esum_q - old_e + SUM_W'(est_s1);
				if (!full) begin
					fill_q <= fill_q + W_W'(1);
				end
				ptr_q <= ptr_nxt;
			end
		end
	end

	// read the slot being replaced, write the new pair back in the following cycle
	always_ff @(posedge clk) begin
		if (start) begin
			p_s1       <= p;
			samp_s1    <= samp;
			est_s1     <= est;
			rd_samp_s1 <= samp_mem[p];
			rd_est_s1  <= est_mem[p];
		end
		if (valid_s1) begin
			samp_mem[p_s1] <= samp_s1;
			est_mem[p_s1]  <= est_s1;
		end
	end

endmodule
`default_nettype wire
